FILE: rtl/core/plb_pkg.sv
// Shared types, codes and defaults for the positional list buffer.
package plb_pkg;

	localparam int DEPTH_DEF  = 16;
	localparam int DATA_W_DEF = 32;
	localparam int ACTION_W   = 3;
	localparam int POS_W      = 5;
	localparam int STATUS_W   = 2;

	// Command codes as they arrive on the action field
	typedef enum logic [ACTION_W-1:0] {
		ACT_INS_FRONT = 3'd0,
		ACT_INS_BACK  = 3'd1,
		ACT_INS_POS   = 3'd2,
		ACT_DEL_FRONT = 3'd3,
		ACT_DEL_BACK  = 3'd4,
		ACT_DEL_POS   = 3'd5,
		ACT_DUMP      = 3'd6
	} act_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	// Decoded command class and target
	typedef enum logic [1:0] {
		K_INS  = 2'd0,
		K_DEL  = 2'd1,
		K_DUMP = 2'd2,
		K_BAD  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		W_FRONT = 2'd0,
		W_BACK  = 2'd1,
		W_POS   = 2'd2
	} where_t;

	typedef struct packed {
		kind_t              kind;
		where_t             where;
		logic [POS_W-1:0]   pos;
	} cmd_t;

endpackage

FILE: rtl/core/positional_list_buffer.sv
// Top level of the positional list buffer: command intake plus list engine.
//
// Ordered list of up to DEPTH signed words with insert front/back/after a
// 1-based position, delete front/back/at a 1-based position, and dump.
// Every command except a non-empty dump returns one result with last set;
// a dump returns one result per entry, front first, last set on the final
// one (an empty list dumps as a single empty status). Item is zero except
// in dump results. Insert and delete commands run at one item per clock
// while results are accepted, since the whole list is a row of registers
// that shifts as one. A dump holds the engine until every entry is sent:
// at each step it sends cell 0 and rotates the live entries by one place,
// so after the last step the list is back in order. A two-slot command
// queue sits between the intake and the engine. The engine has a single
// result register and takes the next command only when that register is
// empty or its item is accepted in the same cycle, so a stalled receiver
// stops the engine and, once both queue slots fill, drops cmd_ready. An
// accepted command goes through a queue slot and then the result register.
// No clearing pass after reset: entries are only read below the fill count.
module positional_list_buffer #(
	parameter int DEPTH      = plb_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = plb_pkg::DATA_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  logic [plb_pkg::ACTION_W-1:0]      action,
	input  logic signed [DATA_WIDTH-1:0]      value,
	input  logic [plb_pkg::POS_W-1:0]         position,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [plb_pkg::STATUS_W-1:0]      status,
	output logic signed [DATA_WIDTH-1:0]      item,
	output logic                              last
);
	import plb_pkg::*;

	// queued command between intake and engine
	logic                  q_valid;
	logic                  q_ready;
	cmd_t                  q_cmd;
	logic [DATA_WIDTH-1:0] q_value;

	plb_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.action   (action),
		.value    (value),
		.position (position),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd),
		.q_value  (q_value)
	);

	// list engine with result register
	plb_back #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_cmd    (q_cmd),
		.q_value  (q_value),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.status   (status),
		.item     (item),
		.last     (last)
	);

endmodule

FILE: rtl/core/plb_front.sv
// Command intake: decodes each item and holds it in a two-slot queue.
module plb_front #(
	parameter int DATA_WIDTH = plb_pkg::DATA_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  logic [plb_pkg::ACTION_W-1:0]      action,
	input  logic signed [DATA_WIDTH-1:0]      value,
	input  logic [plb_pkg::POS_W-1:0]         position,
	output logic                              q_valid,
	input  logic                              q_ready,
	output plb_pkg::cmd_t                     q_cmd,
	output logic [DATA_WIDTH-1:0]             q_value
);
	import plb_pkg::*;

	cmd_t                  dec;
	cmd_t                  slot_cmd_q [2];
	logic [DATA_WIDTH-1:0] slot_val_q [2];
	logic                  wr_q;
	logic                  rd_q;
	logic [1:0]            fill_q;
	logic                  push;
	logic                  pop;

	always_comb begin
		dec.kind  = K_BAD;
		dec.where = W_FRONT;
		dec.pos   = position;
		case (act_t'(action))
			ACT_INS_FRONT: begin dec.kind = K_INS;  dec.where = W_FRONT; end
			ACT_INS_BACK:  begin dec.kind = K_INS;  dec.where = W_BACK;  end
			ACT_INS_POS:   begin dec.kind = K_INS;  dec.where = W_POS;   end
			ACT_DEL_FRONT: begin dec.kind = K_DEL;  dec.where = W_FRONT; end
			ACT_DEL_BACK:  begin dec.kind = K_DEL;  dec.where = W_BACK;  end
			ACT_DEL_POS:   begin dec.kind = K_DEL;  dec.where = W_POS;   end
			ACT_DUMP:      begin dec.kind = K_DUMP; end
			default:       begin dec.kind = K_BAD;  end
		endcase
	end

	assign cmd_ready = (fill_q != 2'd2);
	assign q_valid   = (fill_q != 2'd0);
	assign push      = cmd_valid && cmd_ready;
	assign pop       = q_valid && q_ready;
	assign q_cmd     = slot_cmd_q[rd_q];
	assign q_value   = slot_val_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_cmd_q[wr_q] <= dec;
			slot_val_q[wr_q] <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/plb_back.sv
// List storage and command execution with a registered result stage.
module plb_back #(
	parameter int DEPTH      = plb_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = plb_pkg::DATA_W_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  plb_pkg::cmd_t                     q_cmd,
	input  logic [DATA_WIDTH-1:0]             q_value,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [plb_pkg::STATUS_W-1:0]      status,
	output logic signed [DATA_WIDTH-1:0]      item,
	output logic                              last
);
	import plb_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [1:0] {
		S_RUN  = 2'b01,
		S_DUMP = 2'b10
	} state_t;

	logic [DATA_WIDTH-1:0] cell_q [DEPTH];
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         dix_q;
	state_t                state_q;
	logic                  res_valid_q;
	status_t               status_q;
	logic [DATA_WIDTH-1:0] item_q;
	logic                  last_q;

	logic                  adv;
	logic                  take;
	logic                  is_full;
	logic                  is_empty;
	logic                  pos_bad;
	logic [CW-1:0]         cnt_m1;
	status_t               stat;
	logic                  do_ins;
	logic                  do_del;
	logic                  do_dump;
	logic [CW-1:0]         k;
	logic                  ins_en;
	logic                  del_en;
	logic                  dump_step;
	logic                  rot;
	logic                  emit;
	logic                  dump_last;

	assign adv      = !res_valid_q || res_ready;
	assign q_ready  = (state_q == S_RUN) && adv;
	assign take     = q_valid && q_ready;
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign cnt_m1   = count_q - CW'(1);
	assign pos_bad  = (q_cmd.pos == '0) || (CMPW'(q_cmd.pos) > CMPW'(count_q));

	// classify against the current fill level
	always_comb begin
		stat    = STAT_OK;
		do_ins  = 1'b0;
		do_del  = 1'b0;
		do_dump = 1'b0;
		k       = '0;
		case (q_cmd.kind)
			K_INS: begin
				if (is_full) stat = STAT_FULL;
				else if (q_cmd.where == W_POS && pos_bad) stat = STAT_RANGE;
				else begin
					do_ins = 1'b1;
					case (q_cmd.where)
						W_BACK:  k = count_q;
						W_POS:   k = CW'(q_cmd.pos);
						default: k = '0;
					endcase
				end
			end
			K_DEL: begin
				if (is_empty) stat = STAT_EMPTY;
				else if (q_cmd.where == W_POS && pos_bad) stat = STAT_RANGE;
				else begin
					do_del = 1'b1;
					case (q_cmd.where)
						W_BACK:  k = cnt_m1;
						W_POS:   k = CW'(q_cmd.pos) - CW'(1);
						default: k = '0;
					endcase
				end
			end
			K_DUMP: begin
				if (is_empty) stat = STAT_EMPTY;
				else do_dump = 1'b1;
			end
			default: stat = STAT_RANGE;
		endcase
	end

	assign ins_en    = take && do_ins;
	assign del_en    = take && do_del;
	assign dump_step = (state_q == S_DUMP) && adv;
	assign rot       = (take && do_dump) || dump_step;
	assign emit      = take || dump_step;
	assign dump_last = (state_q == S_DUMP) ? (dix_q == cnt_m1) : (count_q == CW'(1));

	// Each cell picks from itself, its neighbors, the new word or cell 0.
	// A dump rotates the live part of the list so cell 0 always holds the
	// next entry to send; after count steps the order is back.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic [DATA_WIDTH-1:0] prev_w;
		logic [DATA_WIDTH-1:0] next_w;
		if (i == 0) begin : g_p0
			assign prev_w = cell_q[i];
		end else begin : g_pn
			assign prev_w = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_nl
			assign next_w = cell_q[i];
		end else begin : g_nn
			assign next_w = cell_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (ins_en) begin
				if (IDX == k) cell_q[i] <= q_value;
				else if (IDX > k) cell_q[i] <= prev_w;
			end else if (del_en) begin
				if (IDX >= k) cell_q[i] <= next_w;
			end else if (rot) begin
				if (IDX < cnt_m1) cell_q[i] <= next_w;
				else if (IDX == cnt_m1) cell_q[i] <= cell_q[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dix_q       <= '0;
			state_q     <= S_RUN;
			res_valid_q <= 1'b0;
		end else begin
			if (ins_en) count_q <= count_q + CW'(1);
			else if (del_en) count_q <= cnt_m1;

			case (state_q)
				S_RUN: begin
					if (take && do_dump && !dump_last) begin
						state_q <= S_DUMP;
						dix_q   <= CW'(1);
					end
				end
				S_DUMP: begin
					if (dump_step) begin
						dix_q <= dix_q + CW'(1);
						if (dump_last) state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase

			if (emit) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (rot) begin
				status_q <= STAT_OK;
				item_q   <= cell_q[0];
				last_q   <= dump_last;
			end else begin
				status_q <= stat;
				item_q   <= '0;
				last_q   <= 1'b1;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign item      = item_q;
	assign last      = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("list count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
		(count_q == $past(count_q) - CW'(1)))
		else $error("list count moved by more than one");

	a_dump_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> (dix_q != '0) && (dix_q < count_q))
		else $error("dump index outside live entries");

	a_dump_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |=> (count_q == $past(count_q)))
		else $error("list count changed during dump");

endmodule
